// ===== rtl/bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types and constants of the bitmap glyph row renderer: opcodes,
// register map, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bgr_pkg;

  // input item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // configuration port
  localparam int          PADDR_W          = 3;
  localparam logic        REG_FIRST_CHAR   = 1'b0;
  localparam logic [7:0]  FIRST_CHAR_RESET = 8'd32;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_W,
    S_RD_H,
    S_GOT_H,
    S_RED_SKIP,
    S_RED_HDR,
    S_START,
    S_EMPTY,
    S_ROW_RD,
    S_ROW_DATA,
    S_ROW_OUT
  } state_e;

  // font store read address source
  typedef enum logic [1:0] {
    RD_OFF,
    RD_OFF1,
    RD_BYTE
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    wr_en;
    rd_sel_e rd_sel;
    logic    lat_w;
    logic    lat_h;
    logic    acc_skip;
    logic    acc_hdr;
    logic    acc_sub;
    logic    off_load;
    logic    cnt_inc;
    logic    row_init;
    logic    byte_rd;
    logic    byte_store;
    logic    row_next;
    logic    out_load_row;
    logic    out_load_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic acc_ge;
    logic h_zero;
    logic nb_zero;
    logic last_byte;
    logic last_row;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/bgr_ram.sv =====
// ----------------------------------------------------------------------------
// bgr_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgr_ctrl
// Sequencer of the renderer: accepts requests, walks the glyph headers,
// reduces addresses and steps through the row bytes of the chosen glyph.
// ----------------------------------------------------------------------------
module bgr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             opcode_i,
  input  bgr_pkg::status_t status_i,
  output bgr_pkg::cmd_t    cmd_o
);

  bgr_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = bgr_pkg::RD_OFF;
    in_ready_o   = 1'b0;
    case (state_q)
      bgr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == bgr_pkg::OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = bgr_pkg::S_RD_W;
          end
        end
      end
      // width byte address out
      bgr_pkg::S_RD_W: begin
        cmd_o.rd_sel = bgr_pkg::RD_OFF;
        state_d      = bgr_pkg::S_RD_H;
      end
      // width byte back, height byte address out
      bgr_pkg::S_RD_H: begin
        cmd_o.rd_sel = bgr_pkg::RD_OFF1;
        cmd_o.lat_w  = 1'b1;
        state_d      = bgr_pkg::S_GOT_H;
      end
      // height byte back: skip this glyph or take it
      bgr_pkg::S_GOT_H: begin
        cmd_o.lat_h = 1'b1;
        if (status_i.found) begin
          cmd_o.acc_hdr = 1'b1;
          state_d       = bgr_pkg::S_RED_HDR;
        end else begin
          cmd_o.acc_skip = 1'b1;
          state_d        = bgr_pkg::S_RED_SKIP;
        end
      end
      // bring the next glyph address into the store range
      bgr_pkg::S_RED_SKIP: begin
        if (status_i.acc_ge) begin
          cmd_o.acc_sub = 1'b1;
        end else begin
          cmd_o.off_load = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          state_d        = bgr_pkg::S_RD_W;
        end
      end
      // bring the first row address into the store range
      bgr_pkg::S_RED_HDR: begin
        if (status_i.acc_ge) begin
          cmd_o.acc_sub = 1'b1;
        end else begin
          cmd_o.off_load = 1'b1;
          state_d        = bgr_pkg::S_START;
        end
      end
      bgr_pkg::S_START: begin
        if (status_i.h_zero) begin
          state_d = bgr_pkg::S_EMPTY;
        end else begin
          cmd_o.row_init = 1'b1;
          state_d        = bgr_pkg::S_ROW_RD;
        end
      end
      bgr_pkg::S_EMPTY: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load_empty = 1'b1;
          state_d              = bgr_pkg::S_IDLE;
        end
      end
      // row byte address out
      bgr_pkg::S_ROW_RD: begin
        cmd_o.rd_sel = bgr_pkg::RD_BYTE;
        if (status_i.nb_zero) begin
          state_d = bgr_pkg::S_ROW_OUT;
        end else begin
          cmd_o.byte_rd = 1'b1;
          state_d       = bgr_pkg::S_ROW_DATA;
        end
      end
      // row byte back
      bgr_pkg::S_ROW_DATA: begin
        cmd_o.rd_sel     = bgr_pkg::RD_BYTE;
        cmd_o.byte_store = 1'b1;
        if (status_i.last_byte) begin
          state_d = bgr_pkg::S_ROW_OUT;
        end else begin
          state_d = bgr_pkg::S_ROW_RD;
        end
      end
      bgr_pkg::S_ROW_OUT: begin
        cmd_o.rd_sel = bgr_pkg::RD_BYTE;
        if (!status_i.out_busy) begin
          cmd_o.out_load_row = 1'b1;
          if (status_i.last_row) begin
            state_d = bgr_pkg::S_IDLE;
          end else begin
            cmd_o.row_next = 1'b1;
            state_d        = bgr_pkg::S_ROW_RD;
          end
        end
      end
      default: begin
        state_d = bgr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bgr_datapath.sv =====
// ----------------------------------------------------------------------------
// bgr_datapath
// Font store, glyph address arithmetic, row assembly and the result register.
// ----------------------------------------------------------------------------
module bgr_datapath #(
  parameter int FONT_BYTES   = 4096,
  parameter int HEADER_BYTES = 3,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_HEIGHT   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bgr_pkg::cmd_t    cmd_i,
  output bgr_pkg::status_t status_o,
  input  logic [7:0]       first_char_code_i,
  input  logic [11:0]      write_address_i,
  input  logic [7:0]       write_byte_i,
  input  logic [7:0]       char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      row_pixels_o,
  output logic [5:0]       row_width_o,
  output logic [4:0]       row_number_o,
  output logic             last_row_o,
  output logic             empty_glyph_o,
  output logic             clipped_o
);

  localparam int AW     = $clog2(FONT_BYTES);
  localparam int ACC_W  = ((AW > 14) ? AW : 14) + 1;
  localparam int EMIT_W = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
  localparam int EMIT_H = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;

  logic [7:0]       idx_q, cnt_q;
  logic [AW-1:0]    off_q, row_base_q, byte_addr_q;
  logic [ACC_W-1:0] acc_q;
  logic [7:0]       w_q, h_q;
  logic [4:0]       row_q;
  logic [1:0]       jb_q;
  logic [3:0][7:0]  pix_q;

  logic             out_valid_q;
  logic [31:0]      out_pix_q;
  logic [5:0]       out_width_q;
  logic [4:0]       out_row_q;
  logic             out_last_q, out_empty_q, out_clip_q;

  logic [AW-1:0]    raddr, off1, byte_next;
  logic [7:0]       rdata;
  logic             wr_en;
  logic [5:0]       stride, cols, rows;
  logic [2:0]       nb;
  logic             clip;
  logic [13:0]      skip_bytes;
  logic [AW:0]      row_sum;
  logic [AW-1:0]    row_wrap;
  logic [31:0]      mask_full;

  // font store
  assign wr_en = cmd_i.wr_en & (int'(write_address_i) < FONT_BYTES);

  bgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(write_address_i)),
    .wdata_i (write_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // wrapped address increments
  assign off1      = (off_q == AW'(FONT_BYTES - 1)) ? '0 : off_q + AW'(1);
  assign byte_next = (byte_addr_q == AW'(FONT_BYTES - 1)) ? '0 : byte_addr_q + AW'(1);

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      bgr_pkg::RD_OFF:  raddr = off_q;
      bgr_pkg::RD_OFF1: raddr = off1;
      bgr_pkg::RD_BYTE: raddr = byte_addr_q;
      default:          raddr = off_q;
    endcase
  end

  // glyph geometry
  assign stride     = 6'((9'(w_q) + 9'd7) >> 3);
  assign cols       = (int'(w_q) < EMIT_W) ? 6'(w_q) : 6'(EMIT_W);
  assign rows       = (int'(h_q) < EMIT_H) ? 6'(h_q) : 6'(EMIT_H);
  assign nb         = 3'((7'(cols) + 7'd7) >> 3);
  assign clip       = (int'(w_q) > EMIT_W) || (int'(h_q) > EMIT_H);
  assign skip_bytes = 14'(stride) * 14'(rdata);

  // next row base, one conditional subtract
  assign row_sum  = (AW+1)'(row_base_q) + (AW+1)'(stride);
  assign row_wrap = (row_sum >= (AW+1)'(FONT_BYTES)) ?
                    AW'(row_sum - (AW+1)'(FONT_BYTES)) : AW'(row_sum);

  // keep only the top cols pixel bits
  assign mask_full = ~(32'hFFFF_FFFF >> cols);

  // glyph walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q <= char_code_i - first_char_code_i;
      cnt_q <= '0;
      off_q <= '0;
    end else begin
      if (cmd_i.off_load) begin
        off_q <= AW'(acc_q);
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 8'd1;
      end
    end
    if (cmd_i.lat_w) begin
      w_q <= rdata;
    end
    if (cmd_i.lat_h) begin
      h_q <= rdata;
    end
    if (cmd_i.acc_skip) begin
      acc_q <= ACC_W'(off_q) + ACC_W'(skip_bytes) + ACC_W'(HEADER_BYTES);
    end else if (cmd_i.acc_hdr) begin
      acc_q <= ACC_W'(off_q) + ACC_W'(HEADER_BYTES);
    end else if (cmd_i.acc_sub) begin
      acc_q <= acc_q - ACC_W'(FONT_BYTES);
    end
  end

  // row assembly registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      row_q       <= '0;
      row_base_q  <= off_q;
      byte_addr_q <= off_q;
      jb_q        <= '0;
      pix_q       <= '0;
    end else if (cmd_i.row_next) begin
      row_q       <= row_q + 5'd1;
      row_base_q  <= row_wrap;
      byte_addr_q <= row_wrap;
      jb_q        <= '0;
      pix_q       <= '0;
    end else begin
      if (cmd_i.byte_rd) begin
        byte_addr_q <= byte_next;
      end
      if (cmd_i.byte_store) begin
        pix_q[2'd3 - jb_q] <= rdata;
        jb_q               <= jb_q + 2'd1;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_row || cmd_i.out_load_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_row) begin
      out_pix_q   <= pix_q & mask_full;
      out_width_q <= cols;
      out_row_q   <= row_q;
      out_last_q  <= (6'(row_q) + 6'd1) == rows;
      out_empty_q <= 1'b0;
      out_clip_q  <= clip;
    end else if (cmd_i.out_load_empty) begin
      out_pix_q   <= '0;
      out_width_q <= '0;
      out_row_q   <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
      out_clip_q  <= clip;
    end
  end

  // status back to the controller
  assign status_o.found     = (cnt_q == idx_q);
  assign status_o.acc_ge    = (acc_q >= ACC_W'(FONT_BYTES));
  assign status_o.h_zero    = (h_q == 8'd0);
  assign status_o.nb_zero   = (nb == 3'd0);
  assign status_o.last_byte = ((3'(jb_q) + 3'd1) == nb);
  assign status_o.last_row  = ((6'(row_q) + 6'd1) == rows);
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign row_pixels_o  = out_pix_q;
  assign row_width_o   = out_width_q;
  assign row_number_o  = out_row_q;
  assign last_row_o    = out_last_q;
  assign empty_glyph_o = out_empty_q;
  assign clipped_o     = out_clip_q;

endmodule

// ===== rtl/bitmap_glyph_row_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_glyph_row_renderer
// Variable-width bitmap font character generator with a byte-wide font store.
// ----------------------------------------------------------------------------
// A write request (opcode 0) stores one font byte. A render request (opcode 1)
// takes glyph index = char_code - first_char_code (mod 256) and walks the
// packed glyph list from address 0 through the single read port of the font
// store: each skipped glyph has its width and height bytes read, and its end
// address is then folded back into the store by subtracting FONT_BYTES as
// often as needed (at most 2 times for a 4096 byte store). The chosen glyph
// then has its header read and its first row address folded the same way,
// and each row reads ceil(cols/8) bytes (none for a zero width), cols being
// the width clipped to 32; a zero height glyph gives one empty result
// instead. The render waits whenever the result side stalls. One request is
// worked on at a time; the result register lets the next request be accepted
// while the last row waits. No clearing pass: the font store must be written
// before it is rendered.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer #(
  parameter int FONT_BYTES   = 4096,
  parameter int HEADER_BYTES = 3,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_HEIGHT   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [11:0]                 write_address_i,
  input  logic [7:0]                  write_byte_i,
  input  logic [7:0]                  char_code_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 row_pixels_o,
  output logic [5:0]                  row_width_o,
  output logic [4:0]                  row_number_o,
  output logic                        last_row_o,
  output logic                        empty_glyph_o,
  output logic                        clipped_o
);

  logic [7:0]       first_char_q;
  logic             reg_sel;
  bgr_pkg::cmd_t    cmd;
  bgr_pkg::status_t status;

  // register decode, low address bits are the byte offset
  assign reg_sel = (paddr[bgr_pkg::PADDR_W-1] == bgr_pkg::REG_FIRST_CHAR);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, first_char_q} : 32'd0;

  // first character register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q <= bgr_pkg::FIRST_CHAR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      first_char_q <= pwdata[7:0];
    end
  end

  // sequencer
  bgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, address arithmetic and result register
  bgr_datapath #(
    .FONT_BYTES   (FONT_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .first_char_code_i (first_char_q),
    .write_address_i   (write_address_i),
    .write_byte_i      (write_byte_i),
    .char_code_i       (char_code_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .row_pixels_o      (row_pixels_o),
    .row_width_o       (row_width_o),
    .row_number_o      (row_number_o),
    .last_row_o        (last_row_o),
    .empty_glyph_o     (empty_glyph_o),
    .clipped_o         (clipped_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap glyph row renderer. Font bytes are
// loaded through write requests and glyphs are rendered through render
// requests; a model of the font store walks the glyph list and queues the
// rows that each render must return. Directed glyphs cover clipping, empty
// glyphs, index wrap and address wrap; random fonts with random first codes
// follow. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FONT_BYTES     = 4096;
  localparam int unsigned HDR_BYTES      = 3;
  localparam int unsigned MAX_COLS       = 32;
  localparam int unsigned MAX_ROWS       = 32;
  localparam int unsigned ITEM_TARGET    = 460;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned ADDR_W         = bgr_pkg::PADDR_W;
  localparam logic [ADDR_W-1:0] FIRST_CHAR_ADDR = ADDR_W'(4 * bgr_pkg::REG_FIRST_CHAR);

  typedef struct packed {
    logic [31:0] pixels;
    logic [5:0]  width;
    logic [4:0]  number;
    logic        last;
    logic        empty;
    logic        clipped;
  } glyph_row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [ADDR_W-1:0]  paddr           = '0;
  logic [31:0]        pwdata          = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               opcode_i        = bgr_pkg::OP_WRITE;
  logic [11:0]        write_address_i = '0;
  logic [7:0]         write_byte_i    = '0;
  logic [7:0]         char_code_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [31:0]        row_pixels_o;
  logic [5:0]         row_width_o;
  logic [4:0]         row_number_o;
  logic               last_row_o;
  logic               empty_glyph_o;
  logic               clipped_o;

  // font store model and configuration copy
  bit [7:0]    font_mem [FONT_BYTES];
  bit          font_set [FONT_BYTES];
  bit [7:0]    first_char = bgr_pkg::FIRST_CHAR_RESET;
  bit          read_ok;
  glyph_row_t  pending_rows [$];

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          send_gaps      = 1'b1;
  bit          recv_stalls    = 1'b1;

  bitmap_glyph_row_renderer u_dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // store read, flags any byte that was never written
  function automatic bit [7:0] font_rd(input int unsigned addr);
    int unsigned a;
    a = addr % FONT_BYTES;
    if (!font_set[a]) read_ok = 1'b0;
    return font_mem[a];
  endfunction

  // walk the glyph list; queue the rows when commit is set
  // returns 0 when the walk would touch an unwritten byte
  function automatic bit predict_glyph_rows(input bit [7:0] code, input bit commit);
    bit [7:0]    index;
    bit [7:0]    b;
    bit          clip;
    int unsigned k, i, j, off, w, h, stride, cols, rows;
    glyph_row_t  row;
    read_ok = 1'b1;
    index = code - first_char;
    off = 0;
    for (k = 0; k < index; k++) begin
      w = font_rd(off);
      h = font_rd(off + 1);
      off = (off + ((w + 7) >> 3) * h + HDR_BYTES) % FONT_BYTES;
    end
    w = font_rd(off);
    h = font_rd(off + 1);
    off = (off + HDR_BYTES) % FONT_BYTES;
    stride = (w + 7) >> 3;
    cols = (w < MAX_COLS) ? w : MAX_COLS;
    rows = (h < MAX_ROWS) ? h : MAX_ROWS;
    clip = (w > MAX_COLS) || (h > MAX_ROWS);
    // zero height gives a single empty row
    if (h == 0) begin
      row.pixels = '0;
      row.width = '0;
      row.number = '0;
      row.last = 1'b1;
      row.empty = 1'b1;
      row.clipped = clip;
      if (commit) pending_rows.push_back(row);
      return read_ok;
    end
    for (i = 0; i < rows; i++) begin
      row.pixels = '0;
      for (j = 0; j < cols; j++) begin
        b = font_rd(off + i * stride + (j >> 3));
        if (b[7 - (j & 7)]) row.pixels[31 - j] = 1'b1;
      end
      row.width = 6'(cols);
      row.number = 5'(i);
      row.last = (i + 1 == rows);
      row.empty = 1'b0;
      row.clipped = clip;
      if (commit) pending_rows.push_back(row);
    end
    return read_ok;
  endfunction

  // one request; model updated at acceptance
  task automatic send_request(input logic op, input logic [11:0] addr,
                              input logic [7:0] data, input logic [7:0] code);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    write_address_i <= addr;
    write_byte_i    <= data;
    char_code_i     <= code;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (op == bgr_pkg::OP_WRITE) begin
      font_mem[addr] = data;
      font_set[addr] = 1'b1;
    end else begin
      void'(predict_glyph_rows(code, 1'b1));
    end
  endtask

  task automatic write_font_byte(input logic [11:0] addr, input logic [7:0] data);
    send_request(bgr_pkg::OP_WRITE, addr, data, 8'($urandom));
  endtask

  task automatic render_char(input logic [7:0] code);
    send_request(bgr_pkg::OP_RENDER, 12'($urandom), 8'($urandom), code);
  endtask

  // hold requests until every queued row is back, then let the block settle
  task automatic drain_results(input int unsigned extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // one apb transfer; psel stays up so transfers can follow back to back
  task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
  endtask

  task automatic set_first_char(input logic [7:0] value);
    logic [31:0] rdata;
    apb_transfer(1'b1, FIRST_CHAR_ADDR, {24'd0, value}, rdata);
    first_char = value;
    apb_transfer(1'b0, FIRST_CHAR_ADDR, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== {24'd0, value})
      report_mismatch($sformatf("first char readback %h want %h", rdata, value));
  endtask

  // clipping, zero width, empty glyphs and glyph index wrap
  task automatic test_clip_and_empty();
    logic [31:0] rdata;
    apb_transfer(1'b0, FIRST_CHAR_ADDR, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== {24'd0, bgr_pkg::FIRST_CHAR_RESET})
      report_mismatch($sformatf("first char after reset %h", rdata));
    // width 33, one row: only the first four row bytes are shown
    write_font_byte(12'd0, 8'd33);
    write_font_byte(12'd1, 8'd1);
    write_font_byte(12'd3, 8'hFF);
    write_font_byte(12'd4, 8'h00);
    write_font_byte(12'd5, 8'h80);
    write_font_byte(12'd6, 8'h01);
    // zero width, height 255: 32 blank rows
    write_font_byte(12'd8, 8'd0);
    write_font_byte(12'd9, 8'd255);
    // height zero, narrow and over wide
    write_font_byte(12'd11, 8'd5);
    write_font_byte(12'd12, 8'd0);
    write_font_byte(12'd14, 8'd255);
    write_font_byte(12'd15, 8'd0);
    render_char(8'd32);
    render_char(8'd33);
    render_char(8'd34);
    render_char(8'd35);
    drain_results(SETTLE_CYCLES);
    set_first_char(8'hFF);
    render_char(8'd255);
    render_char(8'd2);
    drain_results(SETTLE_CYCLES);
    set_first_char(8'h00);
    render_char(8'd0);
    render_char(8'd1);
    drain_results(SETTLE_CYCLES);
  endtask

  // second glyph header near the top of the store, its rows wrap to zero
  task automatic test_address_wrap();
    write_font_byte(12'd0, 8'd232);
    write_font_byte(12'd1, 8'd141);
    write_font_byte(12'd2, 8'h5A);
    write_font_byte(12'd4092, 8'd16);
    write_font_byte(12'd4093, 8'd2);
    write_font_byte(12'd4095, 8'hC3);
    render_char(first_char + 8'd1);
    drain_results(SETTLE_CYCLES);
  endtask

  // packed glyph list from address zero with random shapes and pixels
  task automatic load_random_font(input int unsigned count);
    int unsigned off, w, h, nbytes, shape, b;
    off = 0;
    repeat (count) begin
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        w = $urandom_range(30, 40);
        h = $urandom_range(1, 3);
      end else if (shape == 1) begin
        w = $urandom_range(0, 8);
        h = $urandom_range(30, 34);
      end else begin
        w = $urandom_range(0, 17);
        h = $urandom_range(0, 5);
      end
      write_font_byte(12'(off), 8'(w));
      write_font_byte(12'((off + 1) % FONT_BYTES), 8'(h));
      if ($urandom_range(0, 3) == 0)
        write_font_byte(12'((off + 2) % FONT_BYTES), 8'($urandom));
      nbytes = ((w + 7) >> 3) * h;
      for (b = 0; b < nbytes; b++)
        write_font_byte(12'((off + HDR_BYTES + b) % FONT_BYTES), 8'($urandom));
      off = (off + HDR_BYTES + nbytes) % FONT_BYTES;
    end
  endtask

  // random fonts, random first codes, renders mixed with stray writes
  task automatic test_random_fonts();
    int unsigned glyphs, pick;
    bit [7:0]    code;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET * 4 / 5) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      drain_results(SETTLE_CYCLES);
      pick = $urandom_range(0, 3);
      set_first_char(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
      glyphs = $urandom_range(1, 8);
      load_random_font(glyphs);
      repeat ($urandom_range(8, 20)) begin
        if ($urandom_range(0, 9) == 0) write_font_byte(12'($urandom), 8'($urandom));
        if ($urandom_range(0, 24) == 0) drain_results(0);
        if ($urandom_range(0, 4) == 0) code = 8'($urandom);
        else code = first_char + 8'($urandom_range(0, glyphs - 1));
        if (!predict_glyph_rows(code, 1'b0))
          code = first_char + 8'($urandom_range(0, glyphs - 1));
        if (predict_glyph_rows(code, 1'b0)) render_char(code);
      end
    end
  endtask

  // result side stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 11) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // row checker
  always @(posedge clk_i) begin
    glyph_row_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d with no render pending", row_number_o));
      end else begin
        want = pending_rows.pop_front();
        if (row_pixels_o !== want.pixels)
          report_mismatch($sformatf("row_pixels %h want %h", row_pixels_o, want.pixels));
        if (row_width_o !== want.width)
          report_mismatch($sformatf("row_width %0d want %0d", row_width_o, want.width));
        if (row_number_o !== want.number)
          report_mismatch($sformatf("row_number %0d want %0d", row_number_o, want.number));
        if (last_row_o !== want.last)
          report_mismatch($sformatf("last_row %b want %b", last_row_o, want.last));
        if (empty_glyph_o !== want.empty)
          report_mismatch($sformatf("empty_glyph %b want %b", empty_glyph_o, want.empty));
        if (clipped_o !== want.clipped)
          report_mismatch($sformatf("clipped %b want %b", clipped_o, want.clipped));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_clip_and_empty();
    test_address_wrap();
    test_random_fonts();
    drain_results(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== bitmap_glyph_row_renderer.f =====
rtl/bgr_pkg.sv
rtl/bgr_ram.sv
rtl/bgr_ctrl.sv
rtl/bgr_datapath.sv
rtl/bitmap_glyph_row_renderer.sv
tb/tb_top.sv
